// ===== hdl/psa_pkg.sv =====
// psa_pkg: shared types, fixed-point constants and helpers for the pixel
// saturation adjust block. No dependencies.
package psa_pkg;

    localparam int FracBits  = 18;
    localparam int FracW     = FracBits + 1;
    localparam int FxOne     = 2 ** FracBits;
    localparam int FxHalf    = FxOne / 2;
    localparam int FxThird   = FxOne / 3;
    localparam int FxTwoThrd = (2 * FxOne) / 3;

    // one quotient bit per divider stage
    localparam int DivSteps  = FracW;

    localparam int GainMax   = 240;
    localparam int GainShift = 4;           // 240 = 16 * 15

    // floor(x / 6) = (x * Recip6) >> Recip6Shift for x < 2^21
    localparam int HMagW       = FracW + 2;
    localparam int Recip6W     = 22;
    localparam int Recip6      = 2796203;
    localparam int Recip6Shift = 24;

    // floor(y / 15) = (y * Recip15) >> Recip15Shift for y < 2^22
    localparam int SatGW        = FracW + 8;
    localparam int YW           = SatGW - GainShift;
    localparam int Recip15W     = 23;
    localparam int Recip15      = 4473925;
    localparam int Recip15Shift = 26;

    localparam logic [1:0] HueBaseRed   = 2'd0;
    localparam logic [1:0] HueBaseGreen = 2'd1;
    localparam logic [1:0] HueBaseBlue  = 2'd2;

    typedef logic [FracW-1:0]    t_frac;
    typedef logic [FracBits-1:0] t_rem;

    typedef struct packed {
        t_frac      lum;
        logic       neg;
        logic [1:0] base;
    } t_side;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix;

    // floor(c * 2^18 / 255) = c * 1028 + floor(4c / 255)
    function automatic t_frac chan_to_frac(logic [7:0] c);
        t_frac base;
        t_frac corr;
        base = t_frac'({c, 10'b0}) + t_frac'({c, 2'b0});
        corr = t_frac'(c >= 8'd64) + t_frac'(c >= 8'd128) + t_frac'(c >= 8'd192)
             + t_frac'(c == 8'd255);
        return base + corr;
    endfunction

endpackage

// ===== hdl/pixel_saturation_adjust_core.sv =====
// Pixel saturation adjust, top level: RGB -> HSL, saturation times gain/240,
// HSL -> RGB. Depends on psa_pkg, psa_front, psa_div and psa_back.
//
// Takes one pixel per clock while o_ready is high and returns one adjusted
// pixel for each, in order. An accepted word passes through 3 front stages,
// 19 divider stages (one quotient bit each, the two 18-bit fraction divisions
// run side by side), 6 back-end stages and the output register. A stall on
// the output parks one word in a skid register and then holds the whole
// pipeline. sat_gain is 0..240 (larger values act as 240) and
// should only be written while no pixel is in flight.
module pixel_saturation_adjust_core import psa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_red_out,
    output logic [7:0] o_green_out,
    output logic [7:0] o_blue_out,
    input  logic       i_sat_gain_we,
    input  logic [7:0] i_sat_gain
);

    logic [7:0] r_sat_gain;
    logic       r_out_valid, r_sk_valid;
    t_pix       r_out, r_sk;

    logic  adv;
    logic  f_valid, d_valid, b_valid;
    t_frac f_sat_x, f_sat_d, f_hue_x, f_hue_d, d_sat, d_hue;
    t_side f_side, d_side;
    t_pix  b_pix;

    assign adv     = !r_sk_valid;
    assign o_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat_gain <= 8'(GainMax);
        end else if (i_sat_gain_we) begin
            r_sat_gain <= i_sat_gain;
        end
    end

    psa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_valid),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_valid (f_valid),
        .o_sat_x (f_sat_x),
        .o_sat_d (f_sat_d),
        .o_hue_x (f_hue_x),
        .o_hue_d (f_hue_d),
        .o_side  (f_side)
    );

    psa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (f_valid),
        .i_sat_x (f_sat_x),
        .i_sat_d (f_sat_d),
        .i_hue_x (f_hue_x),
        .i_hue_d (f_hue_d),
        .i_side  (f_side),
        .o_valid (d_valid),
        .o_sat   (d_sat),
        .o_hue   (d_hue),
        .o_side  (d_side)
    );

    psa_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (d_valid),
        .i_sat   (d_sat),
        .i_hue   (d_hue),
        .i_side  (d_side),
        .i_gain  (r_sat_gain),
        .o_valid (b_valid),
        .o_pix   (b_pix)
    );

    // output register plus skid: the pipeline's last word moves on every adv
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_sk_valid) begin
                r_out_valid <= 1'b1;
                r_sk_valid  <= 1'b0;
            end else begin
                r_out_valid <= b_valid;
            end
        end else if (b_valid) begin
            r_sk_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            r_out <= r_sk_valid ? r_sk : b_pix;
        end else if (adv) begin
            r_sk <= b_pix;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_red_out   = r_out.red;
    assign o_green_out = r_out.green;
    assign o_blue_out  = r_out.blue;

endmodule

// ===== hdl/psa_front.sv =====
// psa_front: channel to fraction, max/min, lightness and divider operands.
// Three register stages. Depends on psa_pkg.
module psa_front import psa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_valid,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output logic       o_valid,
    output t_frac      o_sat_x,
    output t_frac      o_sat_d,
    output t_frac      o_hue_x,
    output t_frac      o_hue_d,
    output t_side      o_side
);

    logic  r_v0, r_v1, r_v2;
    t_frac r_r0, r_g0, r_b0;
    t_frac r_r1, r_g1, r_b1, r_max1, r_min1;
    logic  r_redmax1, r_grnmax1;
    t_frac r_sat_x, r_sat_d, r_hue_x, r_hue_d;
    t_side r_side;

    t_frac       n_max, n_min;
    logic [FracW:0] sum;
    t_frac       delta, den, hue_a, hue_b;
    logic        gray;
    t_side       n_side;

    always_comb begin
        n_max = r_r0;
        if (r_g0 > n_max) n_max = r_g0;
        if (r_b0 > n_max) n_max = r_b0;
        n_min = r_r0;
        if (r_g0 < n_min) n_min = r_g0;
        if (r_b0 < n_min) n_min = r_b0;
    end

    always_comb begin
        sum   = {1'b0, r_max1} + {1'b0, r_min1};
        delta = r_max1 - r_min1;
        gray  = (r_max1 == r_min1);
        if (sum < (FracW+1)'(FxOne)) begin
            den = sum[FracW-1:0];
        end else begin
            den = t_frac'((FracW+1)'(2 * FxOne) - sum);
        end
        n_side.lum = sum[FracW:1];
        priority if (r_redmax1) begin
            n_side.base = HueBaseRed;
            hue_a = r_g1;
            hue_b = r_b1;
        end else if (r_grnmax1) begin
            n_side.base = HueBaseGreen;
            hue_a = r_b1;
            hue_b = r_r1;
        end else begin
            n_side.base = HueBaseBlue;
            hue_a = r_r1;
            hue_b = r_g1;
        end
        n_side.neg = (hue_a < hue_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r0      <= chan_to_frac(i_red);
            r_g0      <= chan_to_frac(i_green);
            r_b0      <= chan_to_frac(i_blue);
            r_r1      <= r_r0;
            r_g1      <= r_g0;
            r_b1      <= r_b0;
            r_max1    <= n_max;
            r_min1    <= n_min;
            r_redmax1 <= (r_r0 == n_max);
            r_grnmax1 <= (r_g0 == n_max);
            // gray: zero dividends, unit divisors
            r_sat_x   <= delta;
            r_sat_d   <= gray ? t_frac'(1) : den;
            r_hue_x   <= n_side.neg ? hue_b - hue_a : hue_a - hue_b;
            r_hue_d   <= gray ? t_frac'(1) : delta;
            r_side    <= n_side;
        end
    end

    assign o_valid = r_v2;
    assign o_sat_x = r_sat_x;
    assign o_sat_d = r_sat_d;
    assign o_hue_x = r_hue_x;
    assign o_hue_d = r_hue_d;
    assign o_side  = r_side;

endmodule

// ===== hdl/psa_div.sv =====
// psa_div: two lockstep restoring dividers, x * 2^18 / d, one quotient bit
// per register stage. Depends on psa_pkg.
module psa_div import psa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_frac i_sat_x,
    input  t_frac i_sat_d,
    input  t_frac i_hue_x,
    input  t_frac i_hue_d,
    input  t_side i_side,
    output logic  o_valid,
    output t_frac o_sat,
    output t_frac o_hue,
    output t_side o_side
);

    typedef struct packed {
        t_rem  rem;
        t_frac quot;
        t_frac dvs;
    } t_lane;

    function automatic t_lane div_step(t_lane l, logic b);
        t_lane       s;
        logic [FracW-1:0] trial;
        trial = {l.rem, b};
        s     = l;
        if (trial >= l.dvs) begin
            s.rem  = t_rem'(trial - l.dvs);
            s.quot = {l.quot[FracW-2:0], 1'b1};
        end else begin
            s.rem  = trial[FracBits-1:0];
            s.quot = {l.quot[FracW-2:0], 1'b0};
        end
        return s;
    endfunction

    logic [DivSteps-1:0] r_vld;
    t_lane r_sat  [DivSteps];
    t_lane r_hue  [DivSteps];
    t_side r_side [DivSteps];
    t_lane n_sat  [DivSteps];
    t_lane n_hue  [DivSteps];

    // the dividend's low 18 bits are zero: seed with x >> 1, shift in x[0]
    always_comb begin
        n_sat[0] = div_step('{rem: i_sat_x[FracW-1:1], quot: '0, dvs: i_sat_d}, i_sat_x[0]);
        n_hue[0] = div_step('{rem: i_hue_x[FracW-1:1], quot: '0, dvs: i_hue_d}, i_hue_x[0]);
        for (int k = 1; k < DivSteps; k++) begin
            n_sat[k] = div_step(r_sat[k-1], 1'b0);
            n_hue[k] = div_step(r_hue[k-1], 1'b0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DivSteps-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 0; k < DivSteps; k++) begin
                r_sat[k] <= n_sat[k];
                r_hue[k] <= n_hue[k];
            end
            for (int k = 1; k < DivSteps; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_vld[DivSteps-1];
    assign o_sat   = r_sat[DivSteps-1].quot;
    assign o_hue   = r_hue[DivSteps-1].quot;
    assign o_side  = r_side[DivSteps-1];

endmodule

// ===== hdl/psa_back.sv =====
// psa_back: hue scaling, saturation gain, HSL to RGB and byte conversion.
// Six register stages. Depends on psa_pkg.
module psa_back import psa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_valid,
    input  t_frac      i_sat,
    input  t_frac      i_hue,
    input  t_side      i_side,
    input  logic [7:0] i_gain,
    output logic       o_valid,
    output t_pix       o_pix
);

    localparam logic [1:0] ZoneRise = 2'd0;
    localparam logic [1:0] ZoneHigh = 2'd1;
    localparam logic [1:0] ZoneFall = 2'd2;
    localparam logic [1:0] ZoneLow  = 2'd3;

    typedef struct packed {
        logic [1:0]          zone;
        logic [FracBits-1:0] t;
    } t_zone;

    function automatic t_zone chan_zone(t_frac h);
        t_zone               z;
        logic [FracW+1:0]    h6;
        logic [FracW+1:0]    h3;
        t_frac               e;
        logic [FracW+1:0]    e6;
        h6 = {h, 2'b0} + {1'b0, h, 1'b0};
        h3 = {2'b0, h} + {1'b0, h, 1'b0};
        e  = t_frac'(FxTwoThrd) - h;
        e6 = {e, 2'b0} + {1'b0, e, 1'b0};
        z.t = '0;
        priority if (h6 < (FracW+2)'(FxOne)) begin
            z.zone = ZoneRise;
            z.t    = h6[FracBits-1:0];
        end else if ({h, 1'b0} < (FracW+1)'(FxOne)) begin
            z.zone = ZoneHigh;
        end else if (h3 < (FracW+2)'(2 * FxOne)) begin
            z.zone = ZoneFall;
            z.t    = e6[FracBits-1:0];
        end else begin
            z.zone = ZoneLow;
        end
        return z;
    endfunction

    function automatic logic [7:0] to_byte(logic signed [FracW+2:0] v);
        logic [FracW+9:0] w;
        logic [10:0]      b;
        w = {v[FracW+1:0], 8'b0} - (FracW+10)'(v[FracW+1:0]);
        b = w[FracW+9:FracBits];
        if (v < 0) begin
            return 8'd0;
        end else if (b > 11'd255) begin
            return 8'd255;
        end
        return b[7:0];
    endfunction

    logic [5:0] r_v;

    // stage 0
    logic [HMagW-1:0] r_hmag;
    logic             r_hneg0;
    logic [SatGW-1:0] r_satg;
    t_frac            r_lum0;
    // stage 1
    logic [HMagW+Recip6W-1:0] r_p6;
    logic [YW+Recip15W-1:0]   r_p15;
    logic                     r_hneg1;
    t_frac                    r_lum1;
    // stage 2
    logic [2*FracW-1:0] r_lsp;
    t_frac              r_sat2, r_lum2, r_hue2;
    // stage 3
    logic signed [FracW+1:0] r_m1_3;
    logic [FracW:0]          r_diff3;
    t_zone                   r_zone3 [3];
    // stage 4
    logic signed [FracW+1:0]      r_m1_4;
    logic [FracW:0]               r_diff4;
    logic [1:0]                   r_zn4  [3];
    logic [FracW+FracBits:0]      r_prod [3];
    // stage 5
    t_pix r_pix;

    logic [7:0]       gain;
    logic [HMagW-1:0] n_hmag;
    logic [HMagW-1:0] hbase;
    logic [FracBits-1:0] d6;
    t_frac            n_hue, n_sat2, ls, hr, hb;
    logic [FracW:0]   hr_s, m2;
    logic signed [FracW+1:0] n_m1;
    t_frac            chan_h [3];
    logic signed [FracW+2:0] vch [3];
    logic [7:0]       bch [3];

    // stage 0: signed hue in sixths as magnitude, gain clamp and product
    always_comb begin
        gain = (i_gain > 8'(GainMax)) ? 8'(GainMax) : i_gain;
        unique case (i_side.base)
            HueBaseGreen: hbase = HMagW'(2 * FxOne);
            HueBaseBlue:  hbase = HMagW'(4 * FxOne);
            default:      hbase = '0;
        endcase
        if (!i_side.neg) begin
            n_hmag = hbase + HMagW'(i_hue);
        end else if (i_side.base == HueBaseRed) begin
            n_hmag = HMagW'(i_hue);
        end else begin
            n_hmag = hbase - HMagW'(i_hue);
        end
    end

    // stage 2: divide results, hue wrap and lum * sat
    always_comb begin
        d6     = r_p6[Recip6Shift +: FracBits];
        n_hue  = (r_hneg1 && d6 != '0) ? t_frac'(FxOne) - {1'b0, d6} : {1'b0, d6};
        n_sat2 = r_p15[Recip15Shift +: FracW];
    end

    // stage 3: m1/m2 and per-channel zone
    always_comb begin
        ls = r_lsp[FracBits +: FracW];
        if (r_lum2 <= t_frac'(FxHalf)) begin
            m2 = {1'b0, r_lum2} + {1'b0, ls};
        end else begin
            m2 = {1'b0, r_lum2} + {1'b0, r_sat2} - {1'b0, ls};
        end
        n_m1 = (FracW+2)'($signed({1'b0, r_lum2, 1'b0}) - $signed({1'b0, m2}));
        hr_s = {1'b0, r_hue2} + (FracW+1)'(FxThird);
        hr   = (hr_s > (FracW+1)'(FxOne)) ? t_frac'(hr_s - (FracW+1)'(FxOne))
                                           : hr_s[FracW-1:0];
        hb   = (r_hue2 >= t_frac'(FxThird)) ? r_hue2 - t_frac'(FxThird)
                                             : r_hue2 + t_frac'(FxOne - FxThird);
        chan_h[0] = hr;
        chan_h[1] = r_hue2;
        chan_h[2] = hb;
    end

    // stage 5: channel value and byte
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            unique case (r_zn4[c])
                ZoneRise, ZoneFall: vch[c] = (FracW+3)'(r_m1_4)
                    + $signed({2'b0, r_prod[c][FracBits +: FracW+1]});
                ZoneHigh: vch[c] = (FracW+3)'(r_m1_4) + $signed({2'b0, r_diff4});
                default:  vch[c] = (FracW+3)'(r_m1_4);
            endcase
            bch[c] = to_byte(vch[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hmag  <= n_hmag;
            r_hneg0 <= i_side.neg && (i_side.base == HueBaseRed);
            r_satg  <= SatGW'(i_sat) * SatGW'(gain);
            r_lum0  <= i_side.lum;

            r_p6    <= (HMagW+Recip6W)'(r_hmag) * (HMagW+Recip6W)'(Recip6);
            r_p15   <= (YW+Recip15W)'(r_satg[SatGW-1:GainShift])
                     * (YW+Recip15W)'(Recip15);
            r_hneg1 <= r_hneg0;
            r_lum1  <= r_lum0;

            r_lsp   <= (2*FracW)'(r_lum1) * (2*FracW)'(n_sat2);
            r_sat2  <= n_sat2;
            r_lum2  <= r_lum1;
            r_hue2  <= n_hue;

            r_m1_3  <= n_m1;
            r_diff3 <= {t_frac'(m2 - {1'b0, r_lum2}), 1'b0};
            for (int c = 0; c < 3; c++) begin
                r_zone3[c] <= chan_zone(chan_h[c]);
            end

            r_m1_4  <= r_m1_3;
            r_diff4 <= r_diff3;
            for (int c = 0; c < 3; c++) begin
                r_zn4[c]  <= r_zone3[c].zone;
                r_prod[c] <= (FracW+FracBits+1)'(r_diff3)
                           * (FracW+FracBits+1)'(r_zone3[c].t);
            end

            r_pix.red   <= bch[0];
            r_pix.green <= bch[1];
            r_pix.blue  <= bch[2];
        end
    end

    assign o_valid = r_v[5];
    assign o_pix   = r_pix;

endmodule

// ===== sim/pixel_saturation_adjust_core_tb.sv =====
// Testbench for pixel_saturation_adjust_core: drives pixels, predicts each
// adjusted pixel in fixed point and checks the output stream. Needs psa_pkg.
`timescale 1ns / 100ps

module pixel_saturation_adjust_core_tb import psa_pkg::*;;

    localparam longint One      = 64'sd262144;
    localparam longint Half     = One / 2;
    localparam longint Third    = One / 3;
    localparam longint TwoThird = (2 * One) / 3;
    localparam int     CycleLimit = 400000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [7:0] i_red = '0;
    logic [7:0] i_green = '0;
    logic [7:0] i_blue = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_red_out;
    logic [7:0] o_green_out;
    logic [7:0] o_blue_out;
    logic       i_sat_gain_we = 1'b0;
    logic [7:0] i_sat_gain = '0;

    logic [7:0] gain_model;
    t_pix       expected_pixels[$];
    int         mismatches = 0;
    int         cycles = 0;
    bit         calm = 1'b0;

    pixel_saturation_adjust_core dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic longint hue_chan(longint m1, longint m2, longint h);
        if (h < 0) h += One;
        if (h > One) h -= One;
        if (6 * h < One) return m1 + ((m2 - m1) * 6 * h) / One;
        if (2 * h < One) return m2;
        if (3 * h < 2 * One) return m1 + ((m2 - m1) * 6 * (TwoThird - h)) / One;
        return m1;
    endfunction

    function automatic logic [7:0] frac_to_byte(longint v);
        longint b;
        if (v < 0) return 8'd0;
        b = (v * 255) / One;
        return (b > 255) ? 8'd255 : b[7:0];
    endfunction

    function automatic t_pix adjust_pixel(t_pix p, logic [7:0] gain_reg);
        longint r, g, b, mx, mn, lum, sat, hue, d, gn, m1, m2;
        t_pix o;
        r = (longint'(p.red) * One) / 255;
        g = (longint'(p.green) * One) / 255;
        b = (longint'(p.blue) * One) / 255;
        mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
        mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
        lum = (mx + mn) / 2;
        sat = 0;
        hue = 0;
        if (mx != mn) begin
            d = mx - mn;
            if (lum < Half) sat = (d * One) / (mx + mn);
            else sat = (d * One) / (2 * One - mx - mn);
            if (r == mx) hue = ((g - b) * One) / d;
            else if (g == mx) hue = 2 * One + ((b - r) * One) / d;
            else hue = 4 * One + ((r - g) * One) / d;
            hue = hue / 6;
            if (hue < 0) hue += One;
        end
        gn = (gain_reg > 240) ? 240 : gain_reg;
        sat = (sat * gn) / 240;
        if (sat == 0) begin
            o.red = frac_to_byte(lum);
            o.green = o.red;
            o.blue = o.red;
        end else begin
            if (lum <= Half) m2 = (lum * (One + sat)) / One;
            else m2 = lum + sat - (lum * sat) / One;
            m1 = 2 * lum - m2;
            o.red = frac_to_byte(hue_chan(m1, m2, hue + Third));
            o.green = frac_to_byte(hue_chan(m1, m2, hue));
            o.blue = frac_to_byte(hue_chan(m1, m2, hue - Third));
        end
        return o;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("status: fail");
            $finish;
        end
    end

    // output side: random stall, check each accepted word
    always @(posedge i_clk) begin
        t_pix want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_pixels.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected word %h %h %h",
                    o_red_out, o_green_out, o_blue_out);
            end else begin
                want = expected_pixels.pop_front();
                if (want.red !== o_red_out || want.green !== o_green_out ||
                    want.blue !== o_blue_out) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: expected %h %h %h, got %h %h %h",
                            want.red, want.green, want.blue,
                            o_red_out, o_green_out, o_blue_out);
                end
            end
        end
        i_ready <= calm || ($urandom_range(99) >= 10);
    end

    // valid stays high between back-to-back words; drain() drops it
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while (!calm && $urandom_range(99) < 10) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_red <= r;
        i_green <= g;
        i_blue <= b;
        do @(posedge i_clk); while (!o_ready);
        expected_pixels.push_back(adjust_pixel({r, g, b}, gain_model));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_gain(logic [7:0] value);
        drain();
        i_sat_gain_we <= 1'b1;
        i_sat_gain <= value;
        @(posedge i_clk);
        i_sat_gain_we <= 1'b0;
        gain_model = value;
    endtask

    task automatic test_directed();
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd200, 8'd10, 8'd90);
        send_pixel(8'd10, 8'd200, 8'd200);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd254, 8'd255);
        send_pixel(8'd170, 8'd85, 8'd85);
    endtask

    task automatic test_random(int n);
        for (int k = 0; k < n; k++)
            send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)));
    endtask

    task automatic test_gains();
        logic [7:0] gains[6] = '{8'd0, 8'd1, 8'd120, 8'd239, 8'd255, 8'd240};
        foreach (gains[k]) begin
            write_gain(gains[k]);
            test_directed();
            test_random(140);
        end
    endtask

    task automatic test_back_to_back();
        // hold off until the pipe empties, then stream with no stalls
        drain();
        calm = 1'b1;
        test_random(120);
        calm = 1'b0;
    endtask

    initial begin
        gain_model = 8'd240;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(100);
        test_gains();
        test_back_to_back();
        drain();
        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
